FILE: src/pvm_pkg.sv
// pvm_pkg: shared types and constants of the PCM voice mixer.
// Used by the mixer core and by its testbench; depends on nothing.
package pvm_pkg;

	// Request kinds
	localparam logic [1:0] REQ_MIX = 2'd0;
	localparam logic [1:0] REQ_SET = 2'd1;
	localparam logic [1:0] REQ_MEM = 2'd2;

	// Voice setting selects
	localparam logic [2:0] SEL_START    = 3'd0;
	localparam logic [2:0] SEL_LENGTH   = 3'd1;
	localparam logic [2:0] SEL_VOLUME   = 3'd2;
	localparam logic [2:0] SEL_PAN      = 3'd3;
	localparam logic [2:0] SEL_LOOP     = 3'd4;
	localparam logic [2:0] SEL_PLAYING  = 3'd5;
	localparam logic [2:0] SEL_FADE_TGT = 3'd6;
	localparam logic [2:0] SEL_FADE_DUR = 3'd7;

	// floor(2^32 / 255): quotient estimate for division by 255
	localparam logic [31:0] RECIP_255 = 32'h0101_0101;
	localparam int DIV_STEPS = 16;

	// One voice entry of the voice memory
	typedef struct packed {
		logic [15:0] start;
		logic [15:0] length;
		logic [15:0] position;
		logic [7:0]  volume;
		logic [7:0]  pan;
		logic        loop_en;
		logic        playing;
		logic [7:0]  target;
		logic [15:0] total;
		logic [15:0] remaining;
	} voice_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_S_RD,
		ST_S_WR,
		ST_F_RD,
		ST_F_EVAL,
		ST_F_DIV,
		ST_F_FADE,
		ST_F_SRD,
		ST_F_SMUL,
		ST_D_MUL,
		ST_D_FIX,
		ST_F_PAN,
		ST_M_START,
		ST_OUT
	} state_t;

endpackage

FILE: src/pvm_req_if.sv
// pvm_req_if: request channel of the mixer (valid/ready plus request fields).
// Depends on nothing.
interface pvm_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [7:0]         step_ms;
	logic [2:0]         voice_index;
	logic [2:0]         setting_select;
	logic [15:0]        setting_value;
	logic [15:0]        mem_address;
	logic signed [15:0] mem_data;

	modport source (output valid, req_type, step_ms, voice_index, setting_select,
		setting_value, mem_address, mem_data, input ready);
	modport sink (input valid, req_type, step_ms, voice_index, setting_select,
		setting_value, mem_address, mem_data, output ready);
endinterface

FILE: src/pvm_res_if.sv
// pvm_res_if: result channel of the mixer (valid/ready plus one stereo frame).
// Depends on nothing.
interface pvm_res_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic [7:0]         playing_mask;

	modport source (output valid, left_out, right_out, playing_mask, input ready);
	modport sink (input valid, left_out, right_out, playing_mask, output ready);
endinterface

FILE: src/pvm_ram.sv
// pvm_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: src/pcm_voice_mixer_core.sv
// pcm_voice_mixer_core: top level of the PCM voice mixer.
// Depends on pvm_pkg, pvm_req_if, pvm_res_if and pvm_ram.
//
//  channel  | dir | handshake       | contents
//  ---------+-----+-----------------+------------------------------------------
//  req      | in  | valid/ready     | mix frame, voice setting or sample write
//  res      | out | valid/ready     | left_out, right_out, playing_mask
//  cfg      | in  | cfg_we          | output gain (cfg_wdata)
//
// Steps: a sample write goes straight to the sample memory; a setting write
// reads, modifies and writes the voice memory. A frame walks the voices one at
// a time: read and evaluate for each voice, then for a playing one a fade step
// when a fade steps (after the divider when the ratio needs it), sample read,
// scale by volume/255 and pan; then the master gain and the output register load.
// Reset clears all voice state through per-voice valid bits; no clearing pass.
// req.ready is high only in idle; a full output register holds the next frame.
// SAMPLE_WORDS must be a power of two.
module pcm_voice_mixer_core
	import pvm_pkg::*;
#(
	parameter int VOICES       = 8,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [7:0] cfg_wdata,
	pvm_req_if.sink   req,
	pvm_res_if.source res
);
	localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int AW    = $clog2(SAMPLE_WORDS);
	localparam int ACC_W = 17 + $clog2(VOICES);
	localparam int NW    = (ACC_W + 8 > 24) ? ACC_W + 8 : 24;
	localparam int VB    = $bits(voice_t);

	state_t state_q, state_nxt;

	logic [7:0]          master_q;
	logic [VW-1:0]       vi_q, v_q;
	logic [2:0]          sel_q;
	logic [15:0]         val_q;
	logic [7:0]          step_q;
	logic [VOICES-1:0]   vld_q;
	logic                rd_vld_q;
	voice_t              cur_q;
	logic [15:0]         div_r_q;
	logic [16:0]         ratio_q;
	logic [3:0]          cnt_q;
	logic [NW-1:0]       n_q, qe_q;
	logic                neg_q, phase_q, side_q;
	logic signed [16:0]  scaled_q;
	logic signed [ACC_W-1:0] acc_l_q, acc_r_q;
	logic [15:0]         res_l_q;
	logic [7:0]          mask_q;
	logic                ov_q;
	logic [15:0]         ol_q, or_q;
	logic [7:0]          om_q;

	// memory ports
	logic          v_we;
	logic [VW-1:0] v_waddr, v_raddr;
	logic [VB-1:0] v_wdata, v_rdata;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_raddr;
	logic [15:0]   s_rdata;

	pvm_ram #(.WIDTH(VB), .DEPTH(VOICES)) u_voice_ram (
		.clk(clk), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
		.raddr(v_raddr), .rdata(v_rdata)
	);

	pvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
		.clk(clk), .we(s_we), .waddr(s_waddr), .wdata(req.mem_data),
		.raddr(s_raddr), .rdata(s_rdata)
	);

	// entry as read; a never-written voice reads as all zero
	voice_t ent, ent_mod, ent_stop, ent_run, cur_adv;
	logic   last_v, req_acc, ent_wrap, ent_stopping, fade_div, fade_full;
	logic [15:0] rem_dec;

	assign ent     = rd_vld_q ? voice_t'(v_rdata) : '0;
	assign last_v  = (v_q == VW'(VOICES - 1));
	assign req_acc = req.valid && req.ready;

	// wrap / stop / fade bookkeeping of a voice entry
	always_comb begin
		rem_dec = (ent.remaining > {8'd0, step_q}) ? ent.remaining - {8'd0, step_q} : 16'd0;
		ent_wrap = (ent.position >= ent.length);
		ent_stopping = (ent.length == 16'd0) || (ent_wrap && !ent.loop_en);
		fade_div = (ent.remaining != 16'd0) && (rem_dec != 16'd0) &&
			(ent.total != 16'd0) && (rem_dec <= ent.total);
		fade_full = (ent.remaining != 16'd0) && (rem_dec != 16'd0) && !fade_div;
		ent_stop = ent;
		ent_stop.playing = 1'b0;
		ent_run = ent;
		if (ent_wrap) begin
			ent_run.position = 16'd0;
		end
		if (ent.remaining != 16'd0) begin
			ent_run.remaining = rem_dec;
			if (rem_dec == 16'd0) begin
				ent_run.volume = ent.target;
			end
		end
		cur_adv = cur_q;
		cur_adv.position = cur_q.position + 16'd1;
	end

	// setting write decoder
	always_comb begin
		ent_mod = ent;
		unique case (sel_q)
			SEL_START:    ent_mod.start = val_q;
			SEL_LENGTH:   ent_mod.length = val_q;
			SEL_VOLUME:   ent_mod.volume = val_q[7:0];
			SEL_PAN:      ent_mod.pan = val_q[7:0];
			SEL_LOOP:     ent_mod.loop_en = val_q[0];
			SEL_PLAYING: begin
				ent_mod.playing = val_q[0];
				if (val_q[0]) begin
					ent_mod.position = 16'd0;
				end
			end
			SEL_FADE_TGT: ent_mod.target = val_q[7:0];
			SEL_FADE_DUR: begin
				ent_mod.total = val_q;
				ent_mod.remaining = val_q;
			end
			default:      ent_mod = ent;
		endcase
	end

	// restoring divider step for the fade ratio
	logic [16:0] div_r2;
	logic        div_ge;
	logic [15:0] div_rn;
	assign div_r2 = {div_r_q, 1'b0};
	assign div_ge = (div_r2 >= {1'b0, cur_q.total});
	assign div_rn = div_ge ? 16'(div_r2 - {1'b0, cur_q.total}) : div_r2[15:0];

	// fade volume update
	logic signed [8:0]  fd;
	logic signed [26:0] fprod;
	logic signed [26:0] fdelta;
	assign fd     = $signed({1'b0, cur_q.target}) - $signed({1'b0, cur_q.volume});
	assign fprod  = fd * $signed({1'b0, ratio_q});
	assign fdelta = fprod >>> 16;

	// sample times volume, and accumulated sum times master volume
	logic signed [24:0]      sprod;
	logic signed [ACC_W-1:0] msrc;
	logic signed [ACC_W+8:0] mprod;
	assign sprod = $signed(s_rdata) * $signed({1'b0, cur_q.volume});
	assign msrc  = side_q ? acc_r_q : acc_l_q;
	assign mprod = msrc * $signed({1'b0, master_q});

	// division by 255: reciprocal estimate, then one correction
	logic [NW+31:0] qprod;
	logic [NW+7:0]  q255, qrem;
	logic [NW-1:0]  qfix;
	logic [NW:0]    qs;
	logic [15:0]    qsat;
	assign qprod = n_q * RECIP_255;
	assign q255  = {qe_q, 8'd0} - {8'd0, qe_q};
	assign qrem  = {8'd0, n_q} - q255;
	assign qfix  = qe_q + NW'(qrem >= (NW+8)'(255));
	assign qs    = neg_q ? -{1'b0, qfix} : {1'b0, qfix};
	always_comb begin
		if (!neg_q) begin
			qsat = (qfix > NW'(32767)) ? 16'h7fff : qfix[15:0];
		end else begin
			qsat = (qfix > NW'(32768)) ? 16'h8000 : qs[15:0];
		end
	end

	// pan: attenuate one side, truncating toward zero
	logic signed [7:0]  pan;
	logic signed [8:0]  fac;
	logic signed [25:0] pprod, ptr;
	logic signed [16:0] l_val, r_val;
	assign pan   = $signed(cur_q.pan);
	assign fac   = pan[7] ? (9'sd128 + 9'(pan)) : (9'sd128 - 9'(pan));
	assign pprod = scaled_q * fac;
	assign ptr   = (pprod + (pprod[25] ? 26'sd127 : 26'sd0)) >>> 7;
	assign l_val = (pan > 8'sd0) ? ptr[16:0] : scaled_q;
	assign r_val = (pan < 8'sd0) ? ptr[16:0] : scaled_q;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.req_type == REQ_MIX) begin
						state_nxt = ST_F_RD;
					end else if (req.req_type == REQ_SET && int'(req.voice_index) < VOICES) begin
						state_nxt = ST_S_RD;
					end
				end
			end
			ST_S_RD:   state_nxt = ST_S_WR;
			ST_S_WR:   state_nxt = ST_IDLE;
			ST_F_RD:   state_nxt = ST_F_EVAL;
			ST_F_EVAL: begin
				if (!ent.playing || ent_stopping) begin
					state_nxt = last_v ? ST_M_START : ST_F_RD;
				end else if (fade_div) begin
					state_nxt = ST_F_DIV;
				end else if (fade_full) begin
					state_nxt = ST_F_FADE;
				end else begin
					state_nxt = ST_F_SRD;
				end
			end
			ST_F_DIV:   state_nxt = (cnt_q == 4'(DIV_STEPS - 1)) ? ST_F_FADE : ST_F_DIV;
			ST_F_FADE:  state_nxt = ST_F_SRD;
			ST_F_SRD:   state_nxt = ST_F_SMUL;
			ST_F_SMUL:  state_nxt = ST_D_MUL;
			ST_D_MUL:   state_nxt = ST_D_FIX;
			ST_D_FIX: begin
				if (!phase_q) begin
					state_nxt = ST_F_PAN;
				end else begin
					state_nxt = side_q ? ST_OUT : ST_M_START;
				end
			end
			ST_F_PAN:   state_nxt = last_v ? ST_M_START : ST_F_RD;
			ST_M_START: state_nxt = ST_D_MUL;
			ST_OUT:     state_nxt = (!ov_q || res.ready) ? ST_IDLE : ST_OUT;
			default:    state_nxt = ST_IDLE;
		endcase
	end

	// memory controls and handshake
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		v_raddr   = (state_q == ST_S_RD) ? vi_q : v_q;
		v_we      = 1'b0;
		v_waddr   = v_q;
		v_wdata   = cur_adv;
		s_we      = (state_q == ST_IDLE) && req.valid && (req.req_type == REQ_MEM);
		s_waddr   = AW'(req.mem_address);
		s_raddr   = AW'({1'b0, cur_q.start} + {1'b0, cur_q.position});
		unique case (state_q)
			ST_S_WR: begin
				v_we    = 1'b1;
				v_waddr = vi_q;
				v_wdata = ent_mod;
			end
			ST_F_EVAL: begin
				v_we    = ent.playing && ent_stopping;
				v_wdata = ent_stop;
			end
			ST_F_SRD: v_we = 1'b1;
			default: v_we = 1'b0;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			master_q <= 8'd255;
			vld_q    <= '0;
			ov_q     <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				master_q <= cfg_wdata;
			end
			if (v_we) begin
				vld_q[v_waddr] <= 1'b1;
			end
			if (state_q == ST_OUT && (!ov_q || res.ready)) begin
				ov_q <= 1'b1;
			end else if (res.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[v_raddr];
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					vi_q    <= VW'(req.voice_index);
					sel_q   <= req.setting_select;
					val_q   <= req.setting_value;
					step_q  <= req.step_ms;
					v_q     <= '0;
					acc_l_q <= '0;
					acc_r_q <= '0;
					mask_q  <= '0;
					side_q  <= 1'b0;
				end
			end
			ST_F_EVAL: begin
				cur_q   <= ent_run;
				div_r_q <= ent.total - rem_dec;
				ratio_q <= fade_full ? 17'h10000 : 17'd0;
				cnt_q   <= '0;
				if (!ent.playing || ent_stopping) begin
					v_q <= v_q + VW'(1);
				end
			end
			ST_F_DIV: begin
				div_r_q <= div_rn;
				ratio_q <= {ratio_q[15:0], div_ge};
				cnt_q   <= cnt_q + 4'd1;
			end
			ST_F_FADE: cur_q.volume <= cur_q.volume + fdelta[7:0];
			ST_F_SRD: begin
				for (int i = 0; i < 8; i++) begin
					if (i < VOICES && int'(v_q) == i) begin
						mask_q[i] <= 1'b1;
					end
				end
			end
			ST_F_SMUL: begin
				phase_q <= 1'b0;
				neg_q   <= sprod[24];
				n_q     <= NW'(sprod[24] ? -sprod : sprod);
			end
			ST_D_MUL: qe_q <= qprod[NW+31:32];
			ST_D_FIX: begin
				scaled_q <= qs[16:0];
				// left result is kept; the right one stays in the divider
				if (phase_q && !side_q) begin
					res_l_q <= qsat;
					side_q  <= 1'b1;
				end
			end
			ST_F_PAN: begin
				acc_l_q <= acc_l_q + ACC_W'(l_val);
				acc_r_q <= acc_r_q + ACC_W'(r_val);
				v_q     <= v_q + VW'(1);
			end
			ST_M_START: begin
				phase_q <= 1'b1;
				neg_q   <= mprod[ACC_W+8];
				n_q     <= NW'(mprod[ACC_W+8] ? -mprod : mprod);
			end
			ST_OUT: begin
				if (!ov_q || res.ready) begin
					ol_q <= res_l_q;
					or_q <= qsat;
					om_q <= mask_q;
				end
			end
			default: ;
		endcase
	end

	assign res.valid        = ov_q;
	assign res.left_out     = $signed(ol_q);
	assign res.right_out    = $signed(or_q);
	assign res.playing_mask = om_q;

endmodule

FILE: verif/pcm_voice_mixer_core_tb.sv
`timescale 1ns / 1ps
// pcm_voice_mixer_core_tb: self-checking testbench of the PCM voice mixer core.
// Depends on pvm_pkg, pvm_req_if, pvm_res_if and pcm_voice_mixer_core.
module pcm_voice_mixer_core_tb;
	import pvm_pkg::*;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  step_ms;
		logic [2:0]  voice;
		logic [2:0]  sel;
		logic [15:0] value;
		logic [15:0] addr;
		logic [15:0] data;
	} mix_req_t;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic [7:0]  mask;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = 8'd0;

	pvm_req_if req_ch();
	pvm_res_if res_ch();

	pcm_voice_mixer_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req_ch.sink), .res(res_ch.source)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state
	logic signed [15:0] mem_img [0:65535];
	logic [15:0] v_start [8], v_len [8], v_pos [8], v_total [8], v_rem [8];
	logic [7:0]  v_vol [8], v_tgt [8];
	logic signed [7:0] v_pan [8];
	bit v_loop [8], v_play [8];
	logic [7:0] gain = 8'd255;

	mix_req_t pending_reqs [$];
	frame_t   expected_frames [$];
	int errors = 0;

	function automatic int sat16(int x);
		if (x > 32767) return 32767;
		if (x < -32768) return -32768;
		return x;
	endfunction

	// Walk all voices for one frame and build the expected output.
	function automatic frame_t mix_frame(logic [7:0] step);
		frame_t f;
		int acc_l, acc_r, s, sc, l, r, d, q;
		longint ratio, x;
		int rem, tot;
		acc_l = 0;
		acc_r = 0;
		for (int v = 0; v < 8; v++) begin
			if (!v_play[v]) continue;
			if (v_len[v] == 0) begin
				v_play[v] = 0;
				continue;
			end
			if (v_pos[v] >= v_len[v]) begin
				if (v_loop[v]) v_pos[v] = 0;
				else begin
					v_play[v] = 0;
					continue;
				end
			end
			if (v_rem[v] > 0) begin
				rem = v_rem[v];
				tot = v_total[v];
				rem = (rem > step) ? rem - step : 0;
				v_rem[v] = rem[15:0];
				if (tot == 0 || rem > tot) ratio = 65536;
				else ratio = (longint'(tot - rem) <<< 16) / tot;
				d = int'(v_tgt[v]) - int'(v_vol[v]);
				x = d * ratio + 255 * 65536;
				q = int'(v_vol[v]) + int'(x / 65536) - 255;
				v_vol[v] = q[7:0];
				if (rem == 0) v_vol[v] = v_tgt[v];
			end
			s = mem_img[16'(v_start[v] + v_pos[v])];
			v_pos[v] = v_pos[v] + 16'd1;
			sc = s * int'(v_vol[v]) / 255;
			l = sc;
			r = sc;
			if (v_pan[v] < 0) r = sc * (128 + v_pan[v]) / 128;
			else if (v_pan[v] > 0) l = sc * (128 - v_pan[v]) / 128;
			acc_l += l;
			acc_r += r;
		end
		f.left = 16'(sat16(acc_l * int'(gain) / 255));
		f.right = 16'(sat16(acc_r * int'(gain) / 255));
		for (int v = 0; v < 8; v++) f.mask[v] = v_play[v];
		return f;
	endfunction

	function automatic void predict(mix_req_t q);
		case (q.kind)
			REQ_MEM: mem_img[q.addr] = q.data;
			REQ_SET: begin
				case (q.sel)
					SEL_START:    v_start[q.voice] = q.value;
					SEL_LENGTH:   v_len[q.voice] = q.value;
					SEL_VOLUME:   v_vol[q.voice] = q.value[7:0];
					SEL_PAN:      v_pan[q.voice] = q.value[7:0];
					SEL_LOOP:     v_loop[q.voice] = q.value[0];
					SEL_PLAYING: begin
						v_play[q.voice] = q.value[0];
						if (q.value[0]) v_pos[q.voice] = 0;
					end
					SEL_FADE_TGT: v_tgt[q.voice] = q.value[7:0];
					default: begin
						v_total[q.voice] = q.value;
						v_rem[q.voice] = q.value;
					end
				endcase
			end
			REQ_MIX: expected_frames.push_back(mix_frame(q.step_ms));
			default: ;
		endcase
	endfunction

	// Stimulus builders; random fields everywhere so every bit toggles.
	function automatic mix_req_t rand_req(logic [1:0] kind);
		mix_req_t q;
		q.kind = kind;
		q.step_ms = 8'($urandom);
		q.voice = 3'($urandom);
		q.sel = 3'($urandom);
		q.value = 16'($urandom);
		q.addr = 16'($urandom);
		q.data = 16'($urandom);
		return q;
	endfunction

	function automatic void push_mem(logic [15:0] a, logic [15:0] d);
		mix_req_t q;
		q = rand_req(REQ_MEM);
		q.addr = a;
		q.data = d;
		pending_reqs.push_back(q);
	endfunction

	function automatic void push_set(logic [2:0] v, logic [2:0] sel, logic [15:0] val);
		mix_req_t q;
		q = rand_req(REQ_SET);
		q.voice = v;
		q.sel = sel;
		q.value = val;
		pending_reqs.push_back(q);
	endfunction

	function automatic void push_mix(logic [7:0] step);
		mix_req_t q;
		q = rand_req(REQ_MIX);
		q.step_ms = step;
		pending_reqs.push_back(q);
	endfunction

	// Base region in memory, all written, used by random voices.
	localparam int REGION = 64;
	logic [15:0] region_base;

	function automatic void push_region();
		for (int i = 0; i < REGION; i++) push_mem(region_base + 16'(i), 16'($urandom));
	endfunction

	// Voice setup that only reads inside the written region.
	function automatic void push_voice(logic [2:0] v);
		int len, off;
		len = $urandom_range(1, 20);
		off = $urandom_range(0, REGION - len);
		push_set(v, SEL_START, region_base + 16'(off));
		push_set(v, SEL_LENGTH, 16'(len));
		push_set(v, SEL_VOLUME, 16'($urandom));
		push_set(v, SEL_PAN, 16'($urandom));
		push_set(v, SEL_LOOP, 16'($urandom));
		if ($urandom_range(0, 1)) begin
			push_set(v, SEL_FADE_TGT, 16'($urandom));
			push_set(v, SEL_FADE_DUR, ($urandom_range(0, 3) == 0) ?
				16'hffff : 16'($urandom_range(0, 2000)));
		end
		push_set(v, SEL_PLAYING, 16'h0001 | (16'($urandom) & 16'hfffe));
	endfunction

	// Driver: after each accept the next item may be held back by a random gap;
	// with hold_send set, nothing goes out while a frame is still expected.
	int send_gap = 0;
	bit hold_send = 1'b0;
	always @(posedge clk or negedge arst_n) begin : drv_blk
		int gap;
		mix_req_t q;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_MIX;
			req_ch.step_ms <= '0;
			req_ch.voice_index <= '0;
			req_ch.setting_select <= '0;
			req_ch.setting_value <= '0;
			req_ch.mem_address <= '0;
			req_ch.mem_data <= '0;
			send_gap <= 0;
		end else if (req_ch.valid && !req_ch.ready) begin
		end else begin
			gap = send_gap;
			if (req_ch.valid) begin
				predict(pending_reqs.pop_front());
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				send_gap <= gap - 1;
			end else if (!(hold_send && expected_frames.size() > 0) &&
					pending_reqs.size() > 0) begin
				q = pending_reqs[0];
				req_ch.valid <= 1'b1;
				req_ch.req_type <= q.kind;
				req_ch.step_ms <= q.step_ms;
				req_ch.voice_index <= q.voice;
				req_ch.setting_select <= q.sel;
				req_ch.setting_value <= q.value;
				req_ch.mem_address <= q.addr;
				req_ch.mem_data <= q.data;
				send_gap <= 0;
			end else begin
				req_ch.valid <= 1'b0;
				send_gap <= 0;
			end
		end
	end

	// Monitor with random back-pressure
	int recv_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				frame_t e;
				if (expected_frames.size() == 0) begin
					$display("%0t: unexpected frame L=%0d R=%0d M=%h", $time,
						$signed(res_ch.left_out), $signed(res_ch.right_out),
						res_ch.playing_mask);
					errors++;
				end else begin
					e = expected_frames.pop_front();
					if (e.left !== res_ch.left_out || e.right !== res_ch.right_out ||
							e.mask !== res_ch.playing_mask) begin
						$display("%0t: frame mismatch exp L=%0d R=%0d M=%h act L=%0d R=%0d M=%h",
							$time, $signed(e.left), $signed(e.right), e.mask,
							$signed(res_ch.left_out), $signed(res_ch.right_out),
							res_ch.playing_mask);
						errors++;
					end
				end
				recv_gap <= $urandom_range(0, 6) * $urandom_range(0, 1);
				res_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				res_ch.ready <= 1'b0;
			end else res_ch.ready <= 1'b1;
		end
	end

	// Wait until the core has drained everything already queued.
	task automatic drain();
		while (pending_reqs.size() > 0 || expected_frames.size() > 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_gain(logic [7:0] g);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		gain = g;
	endtask

	// Stimulus
	initial begin
		for (int v = 0; v < 8; v++) begin
			v_start[v] = 0; v_len[v] = 0; v_pos[v] = 0; v_total[v] = 0;
			v_rem[v] = 0; v_vol[v] = 0; v_tgt[v] = 0; v_pan[v] = 0;
			v_loop[v] = 0; v_play[v] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extremes, saturation, pan edges, stop and wrap, zero length.
		push_mem(16'h0000, 16'h7fff);
		push_mem(16'hffff, 16'h8000);
		push_mix(8'd0);
		push_set(3'd0, SEL_START, 16'hffff);
		push_set(3'd0, SEL_LENGTH, 16'd2);
		push_set(3'd0, SEL_VOLUME, 16'hffff);
		push_set(3'd0, SEL_PAN, 16'h0080);
		push_set(3'd0, SEL_PLAYING, 16'd1);
		push_set(3'd1, SEL_VOLUME, 16'd255);
		push_set(3'd1, SEL_PAN, 16'h007f);
		push_set(3'd1, SEL_LOOP, 16'd1);
		push_set(3'd1, SEL_LENGTH, 16'd1);
		push_set(3'd1, SEL_PLAYING, 16'd1);
		push_set(3'd2, SEL_PLAYING, 16'd1);
		push_set(3'd1, SEL_FADE_TGT, 16'd0);
		push_set(3'd1, SEL_FADE_DUR, 16'd300);
		for (int i = 0; i < 4; i++) push_mix(8'd255);
		push_set(3'd0, SEL_PLAYING, 16'd0);
		pending_reqs.push_back(rand_req(2'd3));
		push_mix(8'd100);
		drain();
		write_gain(8'd0);
		push_mix(8'd1);
		drain();
		write_gain(8'd255);

		// Random phases under several gain settings.
		for (int ph = 0; ph < 6; ph++) begin
			region_base = 16'($urandom);
			push_region();
			for (int v = 0; v < 8; v++) push_voice(v[2:0]);
			for (int n = 0; n < 80; n++) begin
				case ($urandom_range(0, 9))
					0: push_voice(3'($urandom));
					1: pending_reqs.push_back(rand_req(2'd3));
					2: push_mem(16'($urandom), 16'($urandom));
					default: push_mix($urandom_range(0, 3) == 0 ? 8'($urandom) :
						8'($urandom_range(0, 20)));
				endcase
			end
			if (ph == 2) begin
				hold_send = 1'b1;
				drain();
				hold_send = 1'b0;
			end
			drain();
			case (ph)
				0: write_gain(8'd0);
				1: write_gain(8'd128);
				2: write_gain(8'd1);
				3: write_gain(8'($urandom));
				default: write_gain(8'd255);
			endcase
		end
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("simulation failed");
		$finish;
	end

endmodule
